// ----- hw/rtl/lirs_pkg.sv -----
// ----------------------------------------------------------------------------
// lirs_pkg: shared constants for the linear interpolation resampler
// Widths, reset values, register indexes and per-beat limits.
// ----------------------------------------------------------------------------
package lirs_pkg;

  // default datapath widths
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  // configuration register widths
  localparam int RATE_W  = 18;
  localparam int LIMIT_W = 32;
  localparam int PHASE_W = RATE_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FROM_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 2'd2;

  // register reset values
  localparam logic [RATE_W-1:0]  FROM_RATE_RST = 18'd48000;
  localparam logic [RATE_W-1:0]  TO_RATE_RST   = 18'd48000;
  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = 32'd0;

  // at most this many result beats per input beat
  localparam int MAX_RESULTS = 48;
  localparam int RES_CNT_W   = 6;
  localparam logic [RES_CNT_W-1:0] RES_CAP = RES_CNT_W'(MAX_RESULTS);

endpackage

// ----- hw/rtl/lirs_in_if.sv -----
// ----------------------------------------------------------------------------
// lirs_in_if: input sample channel
// Valid/ready channel carrying one source sample and its end-of-clip flag.
// ----------------------------------------------------------------------------
interface lirs_in_if #(
  parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          clip_last;

  modport source (output valid, output sample_in, output clip_last, input ready);
  modport sink   (input valid, input sample_in, input clip_last, output ready);
endinterface

// ----- hw/rtl/lirs_out_if.sv -----
// ----------------------------------------------------------------------------
// lirs_out_if: resampled output channel
// Valid/ready channel carrying one result sample and its run-end flag.
// ----------------------------------------------------------------------------
interface lirs_out_if #(
  parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          run_last;

  modport source (output valid, output sample_out, output run_last, input ready);
  modport sink   (input valid, input sample_out, input run_last, output ready);
endinterface

// ----- hw/rtl/linear_interp_resampler_unit.sv -----
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit: streaming linear interpolation resampler
// Converts a mono sample stream from from_rate to to_rate.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : one source sample per beat, clip_last marks the clip's end.
//   out_ch : resampled samples; run_last marks the final result beat
//            caused by one input beat.
//   cfg_*  : write port for from_rate, to_rate and out_limit; write only
//            while the unit is idle.
// Timing
//   One input beat is worked on at a time; in_ch.ready is high only when
//   no beat is in progress. Each interpolated result comes from a
//   bit-serial divide/multiply unit; end-of-clip repeats take cur as is and
//   skip that unit. A beat gives at most 48 results.
// Reset
//   Registers return to 48000/48000/0 and the clip state is cleared.
// Stall
//   A single output register holds a result; while out_ch stalls the unit
//   waits with the next result ready and takes no new input beat until it is loaded.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit #(
  parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lirs_in_if.sink                           in_ch,
  lirs_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [lirs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lirs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int RATE_W  = lirs_pkg::RATE_W;
  localparam int PHASE_W = lirs_pkg::PHASE_W;
  localparam int LIMIT_W = lirs_pkg::LIMIT_W;
  localparam int NCNT_W  = lirs_pkg::RES_CNT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOP = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [RATE_W-1:0]             from_r, from_nxt;
  logic [RATE_W-1:0]             to_r, to_nxt;
  logic [LIMIT_W-1:0]            limit_r, limit_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic [PHASE_W-1:0]            phase_r, phase_nxt;
  logic [LIMIT_W-1:0]            count_r, count_nxt;
  logic [NCNT_W-1:0]             n_r, n_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic                          last_r, last_nxt;
  logic                          ret_tail_r, ret_tail_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [RATE_W-1:0]             to_eff;
  logic                          phase_lt, count_lt, n_lt, more;
  logic                          lerp_start, lerp_done;
  logic signed [SAMPLE_BITS-1:0] lerp_result;

  // zero output rate acts as one
  assign to_eff   = (to_r == '0) ? RATE_W'(1) : to_r;
  assign phase_lt = phase_r < {1'b0, to_eff};
  assign count_lt = count_r < limit_r;
  assign n_lt     = n_r < lirs_pkg::RES_CAP;
  assign more     = n_lt && count_lt && (phase_lt || last_r);

  lirs_lerp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lerp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lerp_start),
    .prev   (prev_r),
    .cur    (cur_r),
    .phase  (phase_r[RATE_W-1:0]),
    .rate   (to_eff),
    .done   (lerp_done),
    .result (lerp_result)
  );

  always_comb begin
    state_nxt      = state_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    limit_nxt      = limit_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    cur_nxt        = cur_r;
    last_nxt       = last_r;
    ret_tail_nxt   = ret_tail_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    lerp_start     = 1'b0;

    // output register drains on a taken beat
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        lirs_pkg::CFG_FROM_RATE: from_nxt  = cfg_data[RATE_W-1:0];
        lirs_pkg::CFG_TO_RATE:   to_nxt    = cfg_data[RATE_W-1:0];
        lirs_pkg::CFG_OUT_LIMIT: limit_nxt = cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cur_nxt  = in_ch.sample_in;
          last_nxt = in_ch.clip_last;
          n_nxt    = '0;
          if (have_prev_r) begin
            state_nxt = S_LOOP;
          end else begin
            have_prev_nxt = 1'b1;
            phase_nxt     = '0;
            state_nxt     = S_TAIL;
          end
        end
      end
      // next interpolated result or close the interval
      S_LOOP: begin
        if (phase_lt && count_lt && n_lt) begin
          lerp_start = 1'b1;
          state_nxt  = S_CALC;
        end else begin
          phase_nxt = phase_lt ? '0 : phase_r - {1'b0, to_eff};
          state_nxt = S_TAIL;
        end
      end
      S_CALC: begin
        if (lerp_done) begin
          res_nxt      = lerp_result;
          count_nxt    = count_r + LIMIT_W'(1);
          n_nxt        = n_r + NCNT_W'(1);
          phase_nxt    = phase_r + {1'b0, from_r};
          ret_tail_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end
      end
      // load the output register once it is free
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_r;
          out_last_nxt   = !more;
          state_nxt      = ret_tail_r ? S_TAIL : S_LOOP;
        end
      end
      // end-of-clip repeats, then wrap up the beat
      S_TAIL: begin
        if (last_r && count_lt && n_lt) begin
          res_nxt      = cur_r;
          count_nxt    = count_r + LIMIT_W'(1);
          n_nxt        = n_r + NCNT_W'(1);
          ret_tail_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          prev_nxt  = cur_r;
          state_nxt = S_IDLE;
          if (last_r) begin
            prev_nxt      = '0;
            have_prev_nxt = 1'b0;
            phase_nxt     = '0;
            count_nxt     = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      from_r      <= lirs_pkg::FROM_RATE_RST;
      to_r        <= lirs_pkg::TO_RATE_RST;
      limit_r     <= lirs_pkg::OUT_LIMIT_RST;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      phase_r     <= '0;
      count_r     <= '0;
      n_r         <= '0;
      ret_tail_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_r      <= from_nxt;
      to_r        <= to_nxt;
      limit_r     <= limit_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      ret_tail_r  <= ret_tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    last_r       <= last_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.run_last   = out_last_r;

endmodule

// ----- hw/rtl/lirs_lerp.sv -----
// ----------------------------------------------------------------------------
// lirs_lerp: bit-serial interpolation unit
// Restoring division of phase by the output rate, one quotient bit per
// cycle, fused with an msb-first shift-add multiply by |cur - prev|,
// then a rounding step.
// ----------------------------------------------------------------------------
module lirs_lerp #(
  parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [SAMPLE_BITS-1:0]     prev,
  input  logic signed [SAMPLE_BITS-1:0]     cur,
  input  logic [lirs_pkg::RATE_W-1:0]       phase,
  input  logic [lirs_pkg::RATE_W-1:0]       rate,
  output logic                              done,
  output logic signed [SAMPLE_BITS-1:0]     result
);

  localparam int MAG_W = SAMPLE_BITS + 1;
  localparam int ACC_W = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam int RES_W = SAMPLE_BITS + 2;

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [lirs_pkg::RATE_W-1:0] rem_r, rem_nxt;
  logic [lirs_pkg::RATE_W-1:0] rate_r, rate_nxt;
  logic [ACC_W-1:0]            acc_r, acc_nxt;
  logic [MAG_W-1:0]            mag_r, mag_nxt;
  logic                        neg_r, neg_nxt;
  logic signed [SAMPLE_BITS-1:0] base_r, base_nxt;
  logic signed [SAMPLE_BITS-1:0] result_r, result_nxt;

  logic signed [MAG_W-1:0]     diff;
  logic [lirs_pkg::RATE_W:0]   rem2;
  logic                        qbit;
  logic [ACC_W-1:0]            rnd;
  logic [MAG_W-1:0]            step;
  logic signed [RES_W-1:0]     sum;

  // difference of the two samples
  assign diff = $signed({cur[SAMPLE_BITS-1], cur}) - $signed({prev[SAMPLE_BITS-1], prev});

  // one quotient bit
  assign rem2 = {rem_r, 1'b0};
  assign qbit = rem2 >= {1'b0, rate_r};

  // round half away from zero, then apply toward cur
  assign rnd  = acc_r + (ACC_W'(1) << (FRAC_BITS - 1));
  assign step = rnd[ACC_W-1:FRAC_BITS];
  assign sum  = neg_r ? $signed(RES_W'(base_r)) - $signed({1'b0, step})
                      : $signed(RES_W'(base_r)) + $signed({1'b0, step});

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    rate_nxt   = rate_r;
    acc_nxt    = acc_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    base_nxt   = base_r;
    result_nxt = result_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(FRAC_BITS);
      rem_nxt  = phase;
      rate_nxt = rate;
      acc_nxt  = '0;
      neg_nxt  = diff[MAG_W-1];
      mag_nxt  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      base_nxt = prev;
    end else if (busy_r && cnt_r != '0) begin
      // divide and accumulate one bit
      rem_nxt = qbit ? lirs_pkg::RATE_W'(rem2 - {1'b0, rate_r})
                     : rem2[lirs_pkg::RATE_W-1:0];
      acc_nxt = {acc_r[ACC_W-2:0], 1'b0} + (qbit ? ACC_W'(mag_r) : '0);
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (busy_r) begin
      result_nxt = sum[SAMPLE_BITS-1:0];
      done_nxt   = 1'b1;
      busy_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r    <= rem_nxt;
    rate_r   <= rate_nxt;
    acc_r    <= acc_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    base_r   <= base_nxt;
    result_r <= result_nxt;
  end

  assign done   = done_r;
  assign result = result_r;

endmodule
